// File: src/cascaded_position_velocity_pid_core_defines.svh
// assertion macros for the cascaded position/velocity pid core
// each macro expects i_clk and i_rst_n in the scope where it is used
`ifndef CASCADED_POSITION_VELOCITY_PID_CORE_DEFINES_SVH
`define CASCADED_POSITION_VELOCITY_PID_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define CPVPID_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cpvpid same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define CPVPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cpvpid next-cycle check failed");

`endif

// File: src/cpvpid_pkg.sv
`timescale 1ns / 1ps

package cpvpid_pkg;

    // loop constants
    localparam int POS_W         = 12;
    localparam int OUTER_I_LIMIT = 10;
    localparam int INNER_I_LIMIT = 10;

    // datapath widths
    localparam int E_W      = POS_W + 1;      // position error
    localparam int D_W      = POS_W + 2;      // error difference / velocity estimate
    localparam int IE_W     = 20;             // inner error, q8
    localparam int DIE_W    = IE_W + 1;       // inner error difference
    localparam int OINT_W   = 32;
    localparam int IINT_W   = 40;
    localparam int KP_W     = 16;
    localparam int GAIN_W   = 24;
    localparam int LIM_W    = 7;
    localparam int OPND_W   = 32;
    localparam int PROD_W   = GAIN_W + 1 + OPND_W;
    localparam int ACC_W    = 48;
    localparam int OQ       = 12;             // outer term fraction bits
    localparam int IQ       = 20;             // inner term fraction bits
    localparam int VQ       = 8;              // velocity target fraction bits
    localparam int VSH      = OQ - VQ;
    localparam int IE_RAW_W = D_W + VQ + 1;
    localparam int DRV_W    = 8;
    localparam int CMP_W    = 8;

    // stream and config port widths
    localparam int IN_TDATA_W  = ((2 * POS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DRV_W + CMP_W + 7) / 8) * 8;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = GAIN_W;

    // servo mapping: ((drive+93)*100 + 4500)/90, reduced by ten
    localparam int DRIVE_OFFSET = 93;
    localparam int SERVO_SCALE  = 100;
    localparam int SERVO_DIV    = 90;
    localparam int SERVO_ROUND  = SERVO_DIV * SERVO_SCALE / 2;
    localparam int SERVO_BIAS   = (DRIVE_OFFSET * SERVO_SCALE + SERVO_ROUND) / 10;
    localparam int SERVO_STEP   = SERVO_SCALE / 10;
    localparam int SERVO_DEN    = SERVO_DIV / 10;
    localparam int SERVO_RSH    = 16;
    localparam int SERVO_RECIP  = ((1 << SERVO_RSH) + SERVO_DEN - 1) / SERVO_DEN;
    localparam int SERVO_CLEAR  = 154;
    localparam int CMP_MAX      = (1 << CMP_W) - 1;

    // config register indexes
    localparam logic [CFG_AW-1:0] CFG_OKP  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_OKI  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_OKD  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_OLIM = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_IKP  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_IKI  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_IKD  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_ILIM = 3'd7;

    // microcode field widths
    localparam int STEP_W = 4;
    localparam int ACT_W  = 4;
    localparam int SEL_W  = 3;
    localparam int COND_W = 2;

    // datapath actions
    localparam logic [ACT_W-1:0] ACT_NONE       = 4'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD       = 4'd1;
    localparam logic [ACT_W-1:0] ACT_OUTER_PREP = 4'd2;
    localparam logic [ACT_W-1:0] ACT_ACC_LOAD   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_ACC_ADD_IO = 4'd4;
    localparam logic [ACT_W-1:0] ACT_ACC_SUM_O  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_INNER_ERR  = 4'd6;
    localparam logic [ACT_W-1:0] ACT_INNER_PREP = 4'd7;
    localparam logic [ACT_W-1:0] ACT_ACC_ADD_II = 4'd8;
    localparam logic [ACT_W-1:0] ACT_ACC_SUM_I  = 4'd9;
    localparam logic [ACT_W-1:0] ACT_DRIVE      = 4'd10;
    localparam logic [ACT_W-1:0] ACT_EMIT       = 4'd11;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd12;

    // multiplier gain select
    localparam logic [SEL_W-1:0] GA_OKP = 3'd0;
    localparam logic [SEL_W-1:0] GA_OKI = 3'd1;
    localparam logic [SEL_W-1:0] GA_OKD = 3'd2;
    localparam logic [SEL_W-1:0] GA_IKP = 3'd3;
    localparam logic [SEL_W-1:0] GA_IKI = 3'd4;
    localparam logic [SEL_W-1:0] GA_IKD = 3'd5;

    // multiplier operand select
    localparam logic [SEL_W-1:0] OB_E    = 3'd0;
    localparam logic [SEL_W-1:0] OB_OINT = 3'd1;
    localparam logic [SEL_W-1:0] OB_ODE  = 3'd2;
    localparam logic [SEL_W-1:0] OB_IE   = 3'd3;
    localparam logic [SEL_W-1:0] OB_IINT = 3'd4;
    localparam logic [SEL_W-1:0] OB_IDE  = 3'd5;

    // jump conditions
    localparam logic [COND_W-1:0] COND_NEXT  = 2'd0;
    localparam logic [COND_W-1:0] COND_NOACC = 2'd1;
    localparam logic [COND_W-1:0] COND_ISCLR = 2'd2;
    localparam logic [COND_W-1:0] COND_BUSY  = 2'd3;

    // program steps
    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_OPREP  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_OPV    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_OIV    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_OSUM   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_IERR   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_IPREP  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_IPV    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_IIV    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_ISUM   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DRIVE  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd11;
    localparam logic [STEP_W-1:0] STEP_CLEAR  = 4'd12;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [SEL_W-1:0]  ga;
        logic [SEL_W-1:0]  ob;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] tgt;
        logic              ret;   // fall through to the wait step instead of step+1
    } t_uword;

    function automatic t_uword uw_make(
        input logic [ACT_W-1:0]  act,
        input logic [SEL_W-1:0]  ga,
        input logic [SEL_W-1:0]  ob,
        input logic [COND_W-1:0] cond,
        input logic [STEP_W-1:0] tgt,
        input logic              ret
    );
        t_uword w;
        w.act  = act;
        w.ga   = ga;
        w.ob   = ob;
        w.cond = cond;
        w.tgt  = tgt;
        w.ret  = ret;
        return w;
    endfunction

    // control store: the multiplier result lands in the step after the one that selects it
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_WAIT:  w = uw_make(ACT_LOAD,       GA_OKP, OB_E,    COND_NOACC, STEP_WAIT,  1'b0);
            STEP_OPREP: w = uw_make(ACT_OUTER_PREP, GA_OKP, OB_E,    COND_ISCLR, STEP_CLEAR, 1'b0);
            STEP_OPV:   w = uw_make(ACT_ACC_LOAD,   GA_OKI, OB_OINT, COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_OIV:   w = uw_make(ACT_ACC_ADD_IO, GA_OKD, OB_ODE,  COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_OSUM:  w = uw_make(ACT_ACC_SUM_O,  GA_OKP, OB_E,    COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_IERR:  w = uw_make(ACT_INNER_ERR,  GA_OKP, OB_E,    COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_IPREP: w = uw_make(ACT_INNER_PREP, GA_IKP, OB_IE,   COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_IPV:   w = uw_make(ACT_ACC_LOAD,   GA_IKI, OB_IINT, COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_IIV:   w = uw_make(ACT_ACC_ADD_II, GA_IKD, OB_IDE,  COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_ISUM:  w = uw_make(ACT_ACC_SUM_I,  GA_OKP, OB_E,    COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_DRIVE: w = uw_make(ACT_DRIVE,      GA_OKP, OB_E,    COND_NEXT,  STEP_WAIT,  1'b0);
            STEP_EMIT:  w = uw_make(ACT_EMIT,       GA_OKP, OB_E,    COND_BUSY,  STEP_EMIT,  1'b1);
            STEP_CLEAR: w = uw_make(ACT_CLEAR,      GA_OKP, OB_E,    COND_BUSY,  STEP_CLEAR, 1'b1);
            default:    w = uw_make(ACT_NONE,       GA_OKP, OB_E,    COND_NEXT,  STEP_WAIT,  1'b1);
        endcase
        return w;
    endfunction

endpackage

// File: src/cascaded_position_velocity_pid_core.sv
`timescale 1ns / 1ps
// channel   | ports                       | word contents (lowest bit first)
// ----------+-----------------------------+----------------------------------------------
// step in   | s_axis_tvalid/tready/tdata  | tdata: measured_position, target_position
//           | s_axis_tuser                | tuser: op (0 step, 1 clear)
// result    | m_axis_tvalid/tready/tdata  | tdata: drive, servo_compare
// config    | i_cfg_we/addr/data          | addr = register index, data = value
//
// control step: wait, outer prep, outer products and sum, inner error, inner prep, inner products
//   and sum, drive, emit, back to wait; clear word: wait, outer prep, clear, back to wait
// the pace is set by the microcode program sharing one 25x32 multiplier over six products
// a new word is accepted only in the wait step; the emit step holds while the output
// register is full and not taken
// i_rst_n is synchronous, active low: loads the default gains, zeroes the loop state

`include "cascaded_position_velocity_pid_core_defines.svh"

module cascaded_position_velocity_pid_core
    import cpvpid_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // measured_position, target_position
    input  logic                   s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // drive, servo_compare
    input  logic                   i_cfg_we,
    input  logic [CFG_AW-1:0]      i_cfg_addr,
    input  logic [CFG_DW-1:0]      i_cfg_data
);

    // sequencer
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            uw;
    logic              in_acc;
    logic              out_busy;
    logic              do_jump;
    logic              do_emit;

    // configuration
    logic [KP_W-1:0]   r_okp, r_oki, r_ikp, r_iki;
    logic [GAIN_W-1:0] r_okd, r_ikd;
    logic [LIM_W-1:0]  r_olim, r_ilim;

    // loop state
    logic signed [E_W-1:0]    r_oel;
    logic signed [OINT_W-1:0] r_oint;
    logic signed [IE_W-1:0]   r_iel;
    logic signed [IINT_W-1:0] r_iint;

    // working registers
    logic                     r_op;
    logic signed [E_W-1:0]    r_e;
    logic signed [D_W-1:0]    r_vel;
    logic signed [D_W-1:0]    r_de;
    logic signed [IE_W-1:0]   r_ie;
    logic signed [DIE_W-1:0]  r_die;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DRV_W-1:0]  r_drive;

    // output register
    logic                     r_m_valid;
    logic signed [DRV_W-1:0]  r_m_drive;
    logic [CMP_W-1:0]         r_m_servo;

    // datapath nets
    logic [GAIN_W-1:0]          gain_sel;
    logic signed [OPND_W-1:0]   opnd_sel;
    logic signed [OPND_W-1:0]   iint_sat;
    logic signed [PROD_W-1:0]   ilim_p;
    logic signed [PROD_W-1:0]   iv_clamp;
    logic signed [ACC_W-1:0]    prod_lo;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    out_lim;
    logic signed [ACC_W-1:0]    sum_clamp;
    logic signed [ACC_W-1:0]    vout_bias;
    logic signed [ACC_W-1:0]    vout_w;
    logic signed [IE_RAW_W-1:0] ie_raw;
    logic signed [IE_W-1:0]     ie_sat;
    logic signed [ACC_W-1:0]    drv_bias;
    logic signed [ACC_W-1:0]    drv_w;
    logic signed [E_W-1:0]      e_in;
    logic signed [OINT_W:0]     oint_sum;
    logic signed [OINT_W-1:0]   oint_sat;
    logic signed [IINT_W:0]     iint_sum;
    logic signed [IINT_W-1:0]   iint_nsat;

    // servo compare mapping
    localparam int SM_W = 13;
    localparam int SP_W = SM_W - 1 + 13;
    localparam int SQ_W = SP_W - SERVO_RSH;
    logic signed [SM_W-1:0] servo_num;
    logic [SP_W-1:0]        servo_prod;
    logic [SQ_W-1:0]        servo_q;
    logic [CMP_W-1:0]       servo_cmp;

    localparam logic signed [IE_RAW_W-1:0] IE_MAX = IE_RAW_W'((1 << (IE_W - 1)) - 1);
    localparam logic signed [IE_RAW_W-1:0] IE_MIN = -IE_RAW_W'(1 << (IE_W - 1));

    // ---------------------------------------------------------------- sequencer
    assign uw            = ucode_rom(r_step);
    assign s_axis_tready = (uw.act == ACT_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_busy      = r_m_valid && !m_axis_tready;
    assign do_emit       = ((uw.act == ACT_EMIT) || (uw.act == ACT_CLEAR)) && !out_busy;

    always_comb begin
        case (uw.cond)
            COND_NOACC: do_jump = !in_acc;
            COND_ISCLR: do_jump = r_op;
            COND_BUSY:  do_jump = out_busy;
            default:    do_jump = 1'b0;
        endcase
        if (do_jump) begin
            n_step = uw.tgt;
        end else if (uw.ret) begin
            n_step = STEP_WAIT;
        end else begin
            n_step = r_step + STEP_W'(1);
        end
    end

    // ---------------------------------------------------------------- multiplier operands
    always_comb begin
        case (uw.ga)
            GA_OKP:  gain_sel = GAIN_W'(r_okp);
            GA_OKI:  gain_sel = GAIN_W'(r_oki);
            GA_OKD:  gain_sel = r_okd;
            GA_IKP:  gain_sel = GAIN_W'(r_ikp);
            GA_IKI:  gain_sel = GAIN_W'(r_iki);
            GA_IKD:  gain_sel = r_ikd;
            default: gain_sel = '0;
        endcase
    end

    // beyond 32 bits any nonzero gain already hits the integral clamp
    always_comb begin
        if (r_iint[IINT_W-1:OPND_W-1] == {(IINT_W - OPND_W + 1){r_iint[IINT_W-1]}}) begin
            iint_sat = r_iint[OPND_W-1:0];
        end else begin
            iint_sat = {r_iint[IINT_W-1], {(OPND_W - 1){~r_iint[IINT_W-1]}}};
        end
    end

    always_comb begin
        case (uw.ob)
            OB_E:    opnd_sel = OPND_W'(r_e);
            OB_OINT: opnd_sel = OPND_W'(r_oint);
            OB_ODE:  opnd_sel = OPND_W'(r_de);
            OB_IE:   opnd_sel = OPND_W'(r_ie);
            OB_IINT: opnd_sel = iint_sat;
            OB_IDE:  opnd_sel = OPND_W'(r_die);
            default: opnd_sel = '0;
        endcase
    end

    // ---------------------------------------------------------------- accumulate and clamp
    always_comb begin
        if (uw.act == ACT_ACC_ADD_IO) begin
            ilim_p = PROD_W'(OUTER_I_LIMIT * (1 << OQ));
        end else begin
            ilim_p = PROD_W'(INNER_I_LIMIT * (1 << IQ));
        end
        if (r_prod > ilim_p) begin
            iv_clamp = ilim_p;
        end else if (r_prod < -ilim_p) begin
            iv_clamp = -ilim_p;
        end else begin
            iv_clamp = r_prod;
        end
    end

    assign prod_lo = $signed(r_prod[ACC_W-1:0]);
    assign acc_sum = r_acc + prod_lo;

    always_comb begin
        if (uw.act == ACT_ACC_SUM_O) begin
            out_lim = $signed(ACC_W'(r_olim) << OQ);
        end else begin
            out_lim = $signed(ACC_W'(r_ilim) << IQ);
        end
        if (acc_sum > out_lim) begin
            sum_clamp = out_lim;
        end else if (acc_sum < -out_lim) begin
            sum_clamp = -out_lim;
        end else begin
            sum_clamp = acc_sum;
        end
    end

    // truncation toward zero: bias negatives before the arithmetic shift
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            vout_bias = ACC_W'((1 << VSH) - 1);
            drv_bias  = ACC_W'((1 << IQ) - 1);
        end else begin
            vout_bias = '0;
            drv_bias  = '0;
        end
    end

    assign vout_w = (r_acc + vout_bias) >>> VSH;
    assign drv_w  = (r_acc + drv_bias) >>> IQ;

    // inner error: velocity target minus estimated velocity in q8, saturated
    assign ie_raw = IE_RAW_W'(vout_w) - (IE_RAW_W'(r_vel) <<< VQ);

    always_comb begin
        if (ie_raw > IE_MAX) begin
            ie_sat = IE_W'(IE_MAX);
        end else if (ie_raw < IE_MIN) begin
            ie_sat = IE_W'(IE_MIN);
        end else begin
            ie_sat = IE_W'(ie_raw);
        end
    end

    // ---------------------------------------------------------------- state updates
    assign e_in = E_W'($signed(s_axis_tdata[2*POS_W-1:POS_W]))
                - E_W'($signed(s_axis_tdata[POS_W-1:0]));

    assign oint_sum = (OINT_W + 1)'(r_oint) + (OINT_W + 1)'(r_e);
    always_comb begin
        if (oint_sum[OINT_W] != oint_sum[OINT_W-1]) begin
            oint_sat = {oint_sum[OINT_W], {(OINT_W - 1){~oint_sum[OINT_W]}}};
        end else begin
            oint_sat = oint_sum[OINT_W-1:0];
        end
    end

    assign iint_sum = (IINT_W + 1)'(r_iint) + (IINT_W + 1)'(r_ie);
    always_comb begin
        if (iint_sum[IINT_W] != iint_sum[IINT_W-1]) begin
            iint_nsat = {iint_sum[IINT_W], {(IINT_W - 1){~iint_sum[IINT_W]}}};
        end else begin
            iint_nsat = iint_sum[IINT_W-1:0];
        end
    end

    // servo: floor((10*drive + 1380)/9) by reciprocal, saturated to 8 bits
    assign servo_num  = SM_W'(SERVO_BIAS) + SM_W'(r_drive) * SM_W'(SERVO_STEP);
    assign servo_prod = SP_W'(servo_num[SM_W-2:0]) * SP_W'(SERVO_RECIP);
    assign servo_q    = servo_prod[SP_W-1:SERVO_RSH];
    assign servo_cmp  = (servo_q > SQ_W'(CMP_MAX)) ? CMP_W'(CMP_MAX) : servo_q[CMP_W-1:0];

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_WAIT;
            r_m_valid <= 1'b0;
            r_okp     <= KP_W'(115);
            r_oki     <= '0;
            r_okd     <= '0;
            r_olim    <= LIM_W'(20);
            r_ikp     <= KP_W'(40960);
            r_iki     <= '0;
            r_ikd     <= '0;
            r_ilim    <= LIM_W'(15);
            r_oel     <= '0;
            r_oint    <= '0;
            r_iel     <= '0;
            r_iint    <= '0;
        end else begin
            r_step <= n_step;

            if (do_emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_OKP:  r_okp  <= i_cfg_data[KP_W-1:0];
                    CFG_OKI:  r_oki  <= i_cfg_data[KP_W-1:0];
                    CFG_OKD:  r_okd  <= i_cfg_data[GAIN_W-1:0];
                    CFG_OLIM: r_olim <= i_cfg_data[LIM_W-1:0];
                    CFG_IKP:  r_ikp  <= i_cfg_data[KP_W-1:0];
                    CFG_IKI:  r_iki  <= i_cfg_data[KP_W-1:0];
                    CFG_IKD:  r_ikd  <= i_cfg_data[GAIN_W-1:0];
                    CFG_ILIM: r_ilim <= i_cfg_data[LIM_W-1:0];
                    default: begin
                    end
                endcase
            end

            case (uw.act)
                ACT_OUTER_PREP: begin
                    r_oel  <= r_e;
                    r_oint <= oint_sat;
                end
                ACT_INNER_PREP: begin
                    r_iel  <= r_ie;
                    r_iint <= iint_nsat;
                end
                ACT_CLEAR: begin
                    r_oel  <= '0;
                    r_oint <= '0;
                    r_iel  <= '0;
                    r_iint <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, gain_sel}) * opnd_sel;

        case (uw.act)
            ACT_LOAD: begin
                if (in_acc) begin
                    r_op <= s_axis_tuser;
                    r_e  <= e_in;
                end
            end
            ACT_OUTER_PREP: begin
                r_vel <= D_W'(r_oel) - D_W'(r_e);
                r_de  <= D_W'(r_e) - D_W'(r_oel);
            end
            ACT_ACC_LOAD: begin
                r_acc <= prod_lo;
            end
            ACT_ACC_ADD_IO, ACT_ACC_ADD_II: begin
                r_acc <= r_acc + ACC_W'(iv_clamp);
            end
            ACT_ACC_SUM_O, ACT_ACC_SUM_I: begin
                r_acc <= sum_clamp;
            end
            ACT_INNER_ERR: begin
                r_ie <= ie_sat;
            end
            ACT_INNER_PREP: begin
                r_die <= DIE_W'(r_ie) - DIE_W'(r_iel);
            end
            ACT_DRIVE: begin
                r_drive <= drv_w[DRV_W-1:0];
            end
            default: begin
            end
        endcase

        if (do_emit) begin
            if (uw.act == ACT_CLEAR) begin
                r_m_drive <= '0;
                r_m_servo <= CMP_W'(SERVO_CLEAR);
            end else begin
                r_m_drive <= r_drive;
                r_m_servo <= servo_cmp;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_servo, r_m_drive};

    // ---------------------------------------------------------------- checks
    logic [DRV_W-1:0] drive_mag;
    logic             out_step;
    assign drive_mag = r_m_drive[DRV_W-1] ? DRV_W'(-r_m_drive) : DRV_W'(r_m_drive);
    assign out_step  = (r_step == STEP_EMIT) || (r_step == STEP_CLEAR);

    // a delivered drive never exceeds the inner clamp
    `CPVPID_ASSERT_SAME(a_drive_in_limit, r_m_valid, drive_mag <= DRV_W'(r_ilim))
    // an accepted word always starts the program at the outer prep step
    `CPVPID_ASSERT_NEXT(a_accept_starts, in_acc, r_step == STEP_OPREP)
    // a new result shows up only from the emit or clear step
    `CPVPID_ASSERT_SAME(a_emit_source, $rose(r_m_valid), $past(out_step))

endmodule
